/* sv/rlfu_pkg.sv */
// ============================================================================
// rlfu_pkg : shared types and constants of the name cache
// Request and response words, controller states, and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
package rlfu_pkg;

    // Fixed field widths of the request and response words.
    localparam int NAME_KEY_W = 32;
    localparam int SLOT_W     = 6;
    localparam int USE_W      = 15;
    localparam int CAP_W      = 7;

    // Request function codes.
    localparam logic FUNC_GET     = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Capacity after reset and the ceiling of the use count.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;
    localparam logic [USE_W-1:0] USE_SAT   = 15'h7FFF;

    typedef struct packed {
        logic                  func;
        logic [NAME_KEY_W-1:0] name_key;
        logic [SLOT_W-1:0]     slot_in;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              was_hit;
        logic              evicted;
        logic              freed;
        logic [USE_W-1:0]  use_count;
        logic              error;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_rel;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

/* sv/rlfu_ctrl.sv */
// ============================================================================
// rlfu_ctrl : request sequencer of the name cache
// Takes one request word at a time, runs the slot scan for a get or a
// single table read for a release, then commits the update and the result.
// ============================================================================
module rlfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rlfu_pkg::t_sts   i_sts,
    output rlfu_pkg::t_cmd   o_cmd
);

    rlfu_pkg::t_state r_state;
    rlfu_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlfu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            rlfu_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.in_is_rel ? rlfu_pkg::S_REL_RD : rlfu_pkg::S_SCAN;
                end
            end
            rlfu_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = rlfu_pkg::S_FINISH;
                end
            end
            rlfu_pkg::S_REL_RD: begin
                n_state = rlfu_pkg::S_FINISH;
            end
            rlfu_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = rlfu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlfu_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/rlfu_datapath.sv */
// ============================================================================
// rlfu_datapath : slot tables, scan unit and result register
// Holds the key and use-count memories, the valid bits and the high-water
// mark, walks the slots one per cycle for a get, and forms the result word.
// ============================================================================
module rlfu_datapath #(
    parameter int MAX_SLOTS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rlfu_pkg::t_cmd               i_cmd,
    output rlfu_pkg::t_sts               o_sts,
    input  rlfu_pkg::t_req               i_in_word,
    input  logic [rlfu_pkg::CAP_W-1:0]   i_capacity,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output rlfu_pkg::t_rsp               o_out_word
);

    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int HW_W  = $clog2(MAX_SLOTS + 1);
    localparam int KW    = (KEY_BITS < rlfu_pkg::NAME_KEY_W) ? KEY_BITS
                                                             : rlfu_pkg::NAME_KEY_W;
    localparam int CMP_W = HW_W + rlfu_pkg::CAP_W;
    localparam int USE_W = rlfu_pkg::USE_W;

    // Slot tables.
    logic [KW-1:0]    key_mem  [MAX_SLOTS];
    logic [USE_W-1:0] uses_mem [MAX_SLOTS];
    logic [KW-1:0]    r_key_q;
    logic [USE_W-1:0] r_uses_q;

    logic [MAX_SLOTS-1:0] r_valid;
    logic [HW_W-1:0]      r_hw;

    // Request and scan registers.
    rlfu_pkg::t_req   r_req;
    logic [HW_W-1:0]  r_rd_idx;
    logic             r_cmp_vld;
    logic [SW-1:0]    r_cmp_idx;
    logic             r_found;
    logic [SW-1:0]    r_found_idx;
    logic [USE_W-1:0] r_found_uses;
    logic             r_have_free;
    logic [SW-1:0]    r_free_idx;
    logic [USE_W-1:0] r_best;
    logic [SW-1:0]    r_best_idx;

    // Result register.
    logic             r_out_vld;
    rlfu_pkg::t_rsp   r_out;

    logic [SW-1:0]    rel_idx;
    logic [SW-1:0]    rd_idx;
    logic             cmp_act;
    logic             cmp_hit;
    logic             issue;
    logic [CMP_W-1:0] eff_cap;
    logic             rel_ok;
    logic [USE_W-1:0] rel_cnt;
    logic [USE_W-1:0] inc_cnt;
    logic [SW-1:0]    wr_idx;
    logic [USE_W-1:0] wr_uses;
    logic             key_we;
    logic             uses_we;
    logic             set_valid;
    logic             clr_valid;
    logic             grow;
    rlfu_pkg::t_rsp   rsp;

    // Read address: the named slot for a release, the scan pointer for a get.
    assign rel_idx = SW'(r_req.slot_in);
    assign rd_idx  = (r_req.func == rlfu_pkg::FUNC_RELEASE) ? rel_idx : r_rd_idx[SW-1:0];

    // Key memory with registered read.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_idx] <= r_req.name_key[KW-1:0];
        end
        r_key_q <= key_mem[rd_idx];
    end

    // Use-count memory with registered read.
    always_ff @(posedge i_clk) begin
        if (uses_we) begin
            uses_mem[wr_idx] <= wr_uses;
        end
        r_uses_q <= uses_mem[rd_idx];
    end

    // Scan compare stage: one slot per cycle, in the cycle after its read.
    assign cmp_act = i_cmd.scan && r_cmp_vld && !r_found;
    assign cmp_hit = cmp_act && r_valid[r_cmp_idx] && (r_key_q == r_req.name_key[KW-1:0]);
    assign issue   = i_cmd.scan && !r_found && !cmp_hit && (r_rd_idx < r_hw);

    // Scan control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_rd_idx    <= '0;
        end else if (i_cmd.accept) begin
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_rd_idx    <= '0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (cmp_hit) begin
                r_found <= 1'b1;
            end
            if (cmp_act && !r_valid[r_cmp_idx]) begin
                r_have_free <= 1'b1;
            end
        end
    end

    // Scan payload registers: request, first free slot, match, least-used slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_word;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx[SW-1:0];
        end
        if (cmp_act && !r_valid[r_cmp_idx] && !r_have_free) begin
            r_free_idx <= r_cmp_idx;
        end
        if (cmp_hit) begin
            r_found_idx  <= r_cmp_idx;
            r_found_uses <= r_uses_q;
        end
        if (cmp_act && ((r_cmp_idx == '0) || (r_uses_q < r_best))) begin
            r_best     <= r_uses_q;
            r_best_idx <= r_cmp_idx;
        end
    end

    // Capacity clamped to the range one to MAX_SLOTS.
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(i_capacity) > CMP_W'(MAX_SLOTS)) begin
            eff_cap = CMP_W'(MAX_SLOTS);
        end else begin
            eff_cap = CMP_W'(i_capacity);
        end
    end

    // Update decision and result word, applied on commit.
    always_comb begin
        rel_ok  = (CMP_W'(r_req.slot_in) < CMP_W'(r_hw)) && r_valid[rel_idx];
        rel_cnt = (r_uses_q != '0) ? (r_uses_q - 1'b1) : '0;
        inc_cnt = (r_found_uses == rlfu_pkg::USE_SAT) ? r_found_uses
                                                      : (r_found_uses + 1'b1);
        wr_idx    = rel_idx;
        wr_uses   = USE_W'(1);
        key_we    = 1'b0;
        uses_we   = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        grow      = 1'b0;
        rsp       = '0;
        if (r_req.func == rlfu_pkg::FUNC_RELEASE) begin
            rsp.slot_out = r_req.slot_in;
            if (rel_ok) begin
                uses_we       = 1'b1;
                wr_uses       = rel_cnt;
                rsp.use_count = rel_cnt;
                if (rel_cnt == '0) begin
                    clr_valid = 1'b1;
                    rsp.freed = 1'b1;
                end
            end else begin
                rsp.error = 1'b1;
            end
        end else begin
            if (r_found) begin
                wr_idx      = r_found_idx;
                uses_we     = 1'b1;
                wr_uses     = inc_cnt;
                rsp.was_hit = 1'b1;
            end else begin
                if (r_have_free) begin
                    wr_idx = r_free_idx;
                end else if (CMP_W'(r_hw) < eff_cap) begin
                    wr_idx = r_hw[SW-1:0];
                    grow   = 1'b1;
                end else begin
                    wr_idx      = r_best_idx;
                    rsp.evicted = r_valid[r_best_idx];
                end
                key_we    = 1'b1;
                uses_we   = 1'b1;
                set_valid = 1'b1;
            end
            rsp.slot_out  = rlfu_pkg::SLOT_W'(wr_idx);
            rsp.use_count = wr_uses;
        end
        key_we    = key_we    && i_cmd.commit;
        uses_we   = uses_we   && i_cmd.commit;
        set_valid = set_valid && i_cmd.commit;
        clr_valid = clr_valid && i_cmd.commit;
        grow      = grow      && i_cmd.commit;
    end

    // Valid bits and high-water mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hw    <= '0;
        end else begin
            if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[wr_idx] <= 1'b0;
            end
            if (grow) begin
                r_hw <= r_hw + 1'b1;
            end
        end
    end

    // Result register: holds a word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Status to the controller.
    assign o_sts.in_is_rel = (i_in_word.func == rlfu_pkg::FUNC_RELEASE);
    assign o_sts.scan_done = r_found || (!r_cmp_vld && !(r_rd_idx < r_hw));
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

endmodule

/* sv/refcounted_lfu_name_cache.sv */
// ============================================================================
// refcounted_lfu_name_cache : reference-counted name cache, LFU replacement
// Fully associative cache of keyed entries with use counts; a get finds or
// fills a slot, a release lowers the count and frees the slot at zero.
// ============================================================================
//
//  Channel   Handshake                  Word / data
//  -------   ------------------------   ------------------------------
//  request   i_in_valid / o_in_stall    i_in_word  (func, key, slot)
//  result    o_out_valid / i_out_stall  o_out_word (slot, flags, count)
//  config    i_cfg_wr_en                i_cfg_wr_data (capacity limit)
//
//  A get scans the slots below hw, the current high-water mark (at most
//  MAX_SLOTS), and reads none of them while the mark is zero;
//  the slot scan reads one slot per cycle from the key and use-count memories,
//  and stops early on a match.
//  A release does one memory read, then the update.
//  One request is in flight at a time; the next one is taken once the result
//  has been written to the output register, even if it is not yet taken.
//  A stall on the result side holds the result word and, once a second result
//  is ready, holds the commit. Reset is synchronous; no clearing pass is needed.
//
module refcounted_lfu_name_cache #(
    parameter int MAX_SLOTS = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rlfu_pkg::t_req                i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rlfu_pkg::t_rsp                o_out_word,
    input  logic                          i_cfg_wr_en,
    input  logic [rlfu_pkg::CAP_W-1:0]    i_cfg_wr_data
);

    logic [rlfu_pkg::CAP_W-1:0] r_capacity;
    rlfu_pkg::t_cmd             cmd;
    rlfu_pkg::t_sts             sts;

    // Capacity limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= rlfu_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // Request sequencer.
    rlfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tables, scan unit and result register.
    rlfu_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_capacity  (r_capacity),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // A committed result is presented on the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("committed result word not presented");

    // Once a request word is taken, no further word is taken until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request word taken while another is in flight");

    // A new result only appears after a commit.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result word appeared without a commit");

    // The commit never overwrites a result that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("commit while a stalled result is held");

endmodule
